>>> hdl/dpls_pkg.sv
// dithered pwm level sequencer: shared types and constants
// used by the channel interfaces, the sequencer, the cells and the top level
package dpls_pkg;

  localparam int unsigned VALUE_W = 20;
  localparam int unsigned LEVEL_W = 16;
  localparam int unsigned SLOT_W  = 4;
  localparam int unsigned WORD_W  = 2 * LEVEL_W;
  // only the low 24 bits of the error feed the quantizer
  localparam int unsigned ERR_W   = 24;
  localparam int unsigned FRAC_W  = 8;

  localparam logic [ERR_W-1:0] ERR_SEED = ERR_W'(127);

  // request kinds
  localparam logic KIND_SET  = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // halfword select
  localparam logic CHAN_UPPER = 1'b0;
  localparam logic CHAN_LOWER = 1'b1;

  // control shared by every cell of the chain
  typedef struct packed {
    logic               run;
    logic               first;
    logic               rotate;
    logic               chan;
    logic [VALUE_W-1:0] value;
  } dpls_cell_ctrl_t;

endpackage

>>> hdl/dpls_if.sv
// request and result channel interfaces with valid/ready handshake
// depends on dpls_pkg for field widths
interface dpls_req_if
  import dpls_pkg::*;
;
  logic               valid;
  logic               ready;
  logic               kind;
  logic               channel;
  logic [VALUE_W-1:0] value;

  modport source (output valid, kind, channel, value, input ready);
  modport sink   (input valid, kind, channel, value, output ready);
endinterface

interface dpls_res_if
  import dpls_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] level_first;
  logic [LEVEL_W-1:0] level_second;
  logic [SLOT_W-1:0]  slot;

  modport source (output valid, level_first, level_second, slot, input ready);
  modport sink   (input valid, level_first, level_second, slot, output ready);
endinterface

>>> hdl/dithered_pwm_level_sequencer.sv
// dual-channel dithered pwm level sequencer, top level
// a tick's result is registered and valid on the next cycle after it is accepted
// a set runs the error token once around the ring of SLOTS cells while busy, no result
// ticks may follow back to back if results are taken; a set blocks requests while busy
// reset clears every level word to zero and the replay index to slot 0
// depends on dpls_pkg, dpls_if, dpls_cell and dpls_seq
module dithered_pwm_level_sequencer
  import dpls_pkg::*;
#(
  parameter int unsigned SLOTS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  dpls_req_if.sink   req_i,
  dpls_res_if.source res_o
);

  localparam int unsigned IW = $clog2(SLOTS);

  dpls_cell_ctrl_t   ctrl;
  logic [IW-1:0]     start_pos;
  logic [SLOTS-1:0]  tok;
  logic [ERR_W-1:0]  err  [SLOTS];
  logic [WORD_W-1:0] word [SLOTS];

  // sequencing and result register
  dpls_seq #(
    .SLOTS (SLOTS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req         (req_i),
    .res         (res_o),
    .head_word_i (word[0]),
    .ctrl_o      (ctrl),
    .start_pos_o (start_pos)
  );

  // ring of cells: words rotate toward cell 0, token runs upward
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    localparam int unsigned PREV = (i + SLOTS - 1) % SLOTS;
    localparam int unsigned NEXT = (i + 1) % SLOTS;
    logic inject;

    assign inject = ctrl.first && (start_pos == IW'(i));

    dpls_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .inject_i  (inject),
      .tok_i     (tok[PREV]),
      .err_i     (err[PREV]),
      .word_nb_i (word[NEXT]),
      .tok_o     (tok[i]),
      .err_o     (err[i]),
      .word_o    (word[i])
    );
  end

endmodule

>>> hdl/dpls_cell.sv
// one slot cell of the level ring: holds a 32-bit level word, runs one
// error diffusion step when the token or a set's injection reaches it; depends on dpls_pkg
module dpls_cell
  import dpls_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dpls_cell_ctrl_t   ctrl_i,
  input  logic              inject_i,
  input  logic              tok_i,
  input  logic [ERR_W-1:0]  err_i,
  input  logic [WORD_W-1:0] word_nb_i,
  output logic              tok_o,
  output logic [ERR_W-1:0]  err_o,
  output logic [WORD_W-1:0] word_o
);

  logic              proc;
  logic [ERR_W-1:0]  err_in;
  logic [ERR_W-1:0]  value_ext;
  logic [ERR_W-1:0]  diff;
  logic [LEVEL_W-1:0] level;
  logic [ERR_W-1:0]  err_d;
  logic [ERR_W-1:0]  err_q;
  logic              tok_q;
  logic [WORD_W-1:0] word_q;

  // diffusion step: quantize, then carry the residue on
  assign proc      = ctrl_i.run && (inject_i || tok_i);
  assign err_in    = inject_i ? ERR_SEED : err_i;
  assign value_ext = ERR_W'(ctrl_i.value);
  assign diff      = value_ext - err_in;
  assign level     = diff[FRAC_W +: LEVEL_W];
  assign err_d     = err_in + {level, {FRAC_W{1'b0}}} - value_ext;

  // word storage, token and error hand-off
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q <= '0;
      tok_q  <= 1'b0;
    end else begin
      tok_q <= proc;
      if (ctrl_i.rotate) begin
        word_q <= word_nb_i;
      end else if (proc) begin
        if (ctrl_i.chan == CHAN_UPPER) begin
          word_q[WORD_W-1:LEVEL_W] <= level;
        end else begin
          word_q[LEVEL_W-1:0] <= level;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc) begin
      err_q <= err_d;
    end
  end

  assign tok_o  = tok_q;
  assign err_o  = err_q;
  assign word_o = word_q;

endmodule

>>> hdl/dpls_seq.sv
// request handshake, set sequencing, replay index and result register
// depends on dpls_pkg and the channel interfaces in dpls_if
module dpls_seq
  import dpls_pkg::*;
#(
  parameter int unsigned SLOTS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  dpls_req_if.sink                 req,
  dpls_res_if.source               res,
  input  logic [WORD_W-1:0]        head_word_i,
  output dpls_cell_ctrl_t          ctrl_o,
  output logic [$clog2(SLOTS)-1:0] start_pos_o
);

  localparam int unsigned IW = $clog2(SLOTS);

  logic               accept;
  logic               is_tick;
  logic               busy_q;
  logic               first_q;
  logic [IW-1:0]      cnt_q;
  logic               chan_q;
  logic [VALUE_W-1:0] value_q;
  logic [IW-1:0]      replay_q;
  logic [IW-1:0]      start_d;
  logic [IW-1:0]      start_q;
  logic               out_valid_q;
  logic [LEVEL_W-1:0] first_lvl_q;
  logic [LEVEL_W-1:0] second_lvl_q;
  logic [SLOT_W-1:0]  slot_q;

  // handshake
  assign req.ready = !busy_q && (!out_valid_q || res.ready);
  assign accept    = req.valid && req.ready;
  assign is_tick   = (req.kind == KIND_TICK);

  // cell holding slot 0 in the rotated ring
  assign start_d = (replay_q == '0) ? '0 : IW'(SLOTS) - replay_q;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      first_q     <= 1'b0;
      cnt_q       <= '0;
      replay_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (busy_q) begin
        first_q <= 1'b0;
        cnt_q   <= cnt_q + 1'b1;
        if (cnt_q == IW'(SLOTS - 1)) begin
          busy_q <= 1'b0;
        end
      end else if (accept && !is_tick) begin
        busy_q  <= 1'b1;
        first_q <= 1'b1;
        cnt_q   <= '0;
      end
      if (accept && is_tick) begin
        out_valid_q <= 1'b1;
        replay_q    <= (replay_q == IW'(SLOTS - 1)) ? '0 : replay_q + 1'b1;
      end else if (res.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // request payload and result payload
  always_ff @(posedge clk_i) begin
    if (accept && !is_tick) begin
      chan_q  <= req.channel;
      value_q <= req.value;
      start_q <= start_d;
    end
    if (accept && is_tick) begin
      first_lvl_q  <= head_word_i[WORD_W-1:LEVEL_W];
      second_lvl_q <= head_word_i[LEVEL_W-1:0];
      slot_q       <= SLOT_W'(replay_q);
    end
  end

  assign ctrl_o.run    = busy_q;
  assign ctrl_o.first  = first_q;
  assign ctrl_o.rotate = accept && is_tick;
  assign ctrl_o.chan   = chan_q;
  assign ctrl_o.value  = value_q;
  assign start_pos_o   = start_q;

  assign res.valid        = out_valid_q;
  assign res.level_first  = first_lvl_q;
  assign res.level_second = second_lvl_q;
  assign res.slot         = slot_q;

endmodule

>>> verif/tb_dithered_pwm_level_sequencer.sv
// self-checking testbench for the dithered pwm level sequencer
// predicts replayed levels with its own error diffusion store and checks every tick result
// depends on dpls_pkg, dpls_if and the dithered_pwm_level_sequencer top level
`timescale 1ns / 100ps

module tb_dithered_pwm_level_sequencer;
  import dpls_pkg::*;

  localparam int unsigned SLOTS          = 16;
  localparam time         HALF_PERIOD    = 10ns;
  localparam int unsigned RESET_CYCLES   = 7;
  localparam int unsigned RANDOM_ITEMS   = 780;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned PRESSURE_TICKS = 40;
  localparam int unsigned DRAIN_CYCLES   = SLOTS + 8;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned MODE_SPAN      = 200;

  localparam logic [WORD_W-1:0]  DIFFUSE_SEED = 32'd127;
  localparam logic [WORD_W-1:0]  QUANT_MASK   = 32'h00FF_FF00;
  localparam logic [VALUE_W-1:0] VALUE_MAX    = 20'd524288;
  localparam logic [VALUE_W-1:0] VALUE_ONES   = '1;

  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_RANDOM,
    RX_PATTERN
  } rx_mode_e;

  typedef struct packed {
    logic [LEVEL_W-1:0] level_first;
    logic [LEVEL_W-1:0] level_second;
    logic [SLOT_W-1:0]  slot;
  } replay_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  dpls_req_if req_if ();
  dpls_res_if res_if ();

  dithered_pwm_level_sequencer #(
    .SLOTS(SLOTS)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .res_o (res_if)
  );

  // predictor state
  logic [WORD_W-1:0] level_words[SLOTS];
  logic [SLOT_W-1:0] replay_ptr;
  replay_t           replay_q[$];

  int unsigned fail_count = 0;
  int unsigned idle_count = 0;
  logic        hold_req   = 1'b0;

  // clock
  always begin
    #(HALF_PERIOD) clk_i = 1'b1;
    #(HALF_PERIOD) clk_i = 1'b0;
  end

  // error diffusion of a fine value into one halfword of every slot
  function automatic void diffuse_level(input logic chan, input logic [VALUE_W-1:0] fine);
    logic [WORD_W-1:0]  err;
    logic [WORD_W-1:0]  quant;
    logic [WORD_W-1:0]  fine_w;
    logic [LEVEL_W-1:0] lvl;
    err    = DIFFUSE_SEED;
    fine_w = WORD_W'(fine);
    for (int i = 0; i < SLOTS; i++) begin
      quant = (fine_w - err) & QUANT_MASK;
      lvl   = quant[FRAC_W +: LEVEL_W];
      err   = err + quant - fine_w;
      if (chan == CHAN_UPPER) begin
        level_words[i][WORD_W-1:LEVEL_W] = lvl;
      end else begin
        level_words[i][LEVEL_W-1:0] = lvl;
      end
    end
  endfunction

  // replay of the current slot, then advance
  function automatic replay_t replay_slot();
    replay_t r;
    r.level_first  = level_words[replay_ptr][WORD_W-1:LEVEL_W];
    r.level_second = level_words[replay_ptr][LEVEL_W-1:0];
    r.slot         = SLOT_W'(replay_ptr);
    replay_ptr     = (replay_ptr == SLOT_W'(SLOTS - 1)) ? '0 : replay_ptr + 1'b1;
    return r;
  endfunction

  // fine value drawn from in-range, full-width, small and edge patterns
  function automatic logic [VALUE_W-1:0] pick_value();
    logic [VALUE_W-1:0] v;
    case ($urandom_range(0, 3))
      0: v = VALUE_W'($urandom_range(0, VALUE_MAX));
      1: v = VALUE_W'($urandom());
      2: v = VALUE_W'($urandom_range(0, 511));
      default: begin
        case ($urandom_range(0, 3))
          0: v = '0;
          1: v = VALUE_MAX;
          2: v = VALUE_ONES;
          default: v = VALUE_W'($urandom_range(0, 2047)) << FRAC_W;
        endcase
      end
    endcase
    return v;
  endfunction

  // send one request and update the prediction when it is accepted
  task automatic send_request(input logic kind, input logic chan, input logic [VALUE_W-1:0] fine);
    @(negedge clk_i);
    req_if.valid   <= 1'b1;
    req_if.kind    <= kind;
    req_if.channel <= chan;
    req_if.value   <= fine;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    if (kind == KIND_SET) begin
      diffuse_level(chan, fine);
    end else begin
      replay_q.push_back(replay_slot());
    end
  endtask

  // tick with random filler in the ignored fields
  task automatic send_tick();
    send_request(KIND_TICK, 1'($urandom()), VALUE_W'($urandom()));
  endtask

  task automatic idle_sender(input int unsigned cycles);
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  // ticks straight after reset replay zero levels from slot 0 on
  task automatic test_reset_state();
    send_tick();
    send_tick();
  endtask

  // extremes of the fine value on both channels, other halfword kept
  task automatic test_extreme_values();
    send_request(KIND_SET, CHAN_UPPER, VALUE_MAX);
    send_request(KIND_SET, CHAN_LOWER, VALUE_ONES);
    send_tick();
    idle_sender(3);
    send_request(KIND_SET, CHAN_UPPER, '0);
    send_request(KIND_SET, CHAN_LOWER, VALUE_W'(8'h80));
    send_tick();
  endtask

  // a full lap of ticks so the replay index wraps back to slot 0
  task automatic test_slot_wrap();
    repeat (SLOTS) send_tick();
  endtask

  // random sets and ticks in bursts with random gaps
  task automatic test_random_traffic();
    int unsigned sent;
    int unsigned burst;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 12);
      for (int unsigned b = 0; b < burst && sent < RANDOM_ITEMS; b++) begin
        if ($urandom_range(0, 99) < 30) begin
          send_request(KIND_SET, 1'($urandom()), pick_value());
        end else begin
          send_tick();
        end
        sent++;
      end
      if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 15));
    end
  endtask

  // long receiver hold-off while ticks keep coming, input must stall
  task automatic test_backpressure();
    hold_req = 1'b1;
    repeat (PRESSURE_TICKS) send_tick();
    send_request(KIND_SET, 1'($urandom()), pick_value());
    repeat (4) send_tick();
  endtask

  // receiver ready pattern, with a counted hold-off on request
  initial begin
    rx_mode_e    mode;
    int unsigned phase;
    int unsigned hold_left;
    mode      = RX_ALWAYS;
    phase     = 0;
    hold_left = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(negedge clk_i);
      phase++;
      if (phase % MODE_SPAN == 0) mode = rx_mode_e'($urandom_range(0, 2));
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        case (mode)
          RX_ALWAYS: res_if.ready <= 1'b1;
          RX_RANDOM: res_if.ready <= ($urandom_range(0, 99) >= 35);
          default:   res_if.ready <= ((phase % 7) >= 3);
        endcase
      end
    end
  end

  // result check against the oldest expected replay
  always @(posedge clk_i) begin
    replay_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (replay_q.size() == 0) begin
        $error("unexpected result: slot %0d", res_if.slot);
        fail_count++;
      end else begin
        want = replay_q.pop_front();
        if (res_if.level_first !== want.level_first) begin
          $error("level_first mismatch: expected %0h, actual %0h",
                 want.level_first, res_if.level_first);
          fail_count++;
        end
        if (res_if.level_second !== want.level_second) begin
          $error("level_second mismatch: expected %0h, actual %0h",
                 want.level_second, res_if.level_second);
          fail_count++;
        end
        if (res_if.slot !== want.slot) begin
          $error("slot mismatch: expected %0d, actual %0d", want.slot, res_if.slot);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles without any accepted request or result
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
      idle_count <= 0;
    end else if (idle_count >= WATCHDOG_LIMIT) begin
      $display("dithered_pwm_level_sequencer verification failed");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  // test sequence
  initial begin
    for (int i = 0; i < SLOTS; i++) level_words[i] = '0;
    replay_ptr     = '0;
    req_if.valid   <= 1'b0;
    req_if.kind    <= KIND_SET;
    req_if.channel <= CHAN_UPPER;
    req_if.value   <= '0;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    idle_sender(2);

    test_reset_state();
    test_extreme_values();
    test_slot_wrap();
    test_random_traffic();
    test_backpressure();

    idle_sender(1);
    while (replay_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && replay_q.size() == 0) begin
      $display("dithered_pwm_level_sequencer verification clean");
    end else begin
      $display("dithered_pwm_level_sequencer verification failed");
    end
    $finish;
  end

endmodule
